### rtl/unix_seconds_to_utc_date_defines.svh
// Assertion macros used by the top level of the Unix time to UTC date converter.
`ifndef UNIX_SECONDS_TO_UTC_DATE_DEFINES_SVH
`define UNIX_SECONDS_TO_UTC_DATE_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, quiet while i_rst_n is low
`define US2UTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, quiet while i_rst_n is low
`define US2UTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/us2utc_pkg.sv
// Types, constants and small tables for the Unix time to UTC date converter.
package us2utc_pkg;

    // Pipeline depth and stage positions
    localparam int NUM_STAGES = 8;
    localparam int S_DAYS     = 0;  // day count from seconds
    localparam int S_SHIFT    = 1;  // day of era, seconds of day
    localparam int S_YOE_ARG  = 2;  // year-of-era numerator, hour
    localparam int S_YOE      = 3;  // year of era, seconds of hour
    localparam int S_DOY      = 4;  // day of year, minute
    localparam int S_MP       = 5;  // March-based month, second
    localparam int S_DATE     = 6;  // year, month, day
    localparam int S_OUT      = 7;  // output register with window check

    // Per-stage load enables handed to the date datapath
    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
    } t_pipe_ctl;

    // Day split: secs / 86400 = (secs >> 7) / 675, by reciprocal 2^35
    localparam logic [25:0] DAY_RECIP     = 26'd50903317;
    localparam int          DAY_SHIFT     = 35;
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;

    // Era split
    localparam logic [19:0] DAYS_TO_EPOCH = 20'd719468;
    localparam logic [19:0] ERA4_START    = 20'd584388;   // 4 * 146097
    localparam logic [19:0] ERA5_START    = 20'd730485;   // 5 * 146097
    localparam logic [17:0] DOE_100Y      = 18'd36524;
    localparam logic [17:0] DOE_200Y      = 18'd73048;
    localparam logic [17:0] DOE_300Y      = 18'd109572;
    localparam logic [17:0] DOE_LAST      = 18'd146096;

    // doe / 1460 = (doe >> 2) / 365, reciprocal 2^25
    localparam logic [16:0] R365_Q4       = 17'd91930;
    localparam int          R365_Q4_SHIFT = 25;
    // t / 365, reciprocal 2^27
    localparam logic [18:0] R365          = 19'd367720;
    localparam int          R365_SHIFT    = 27;
    // yoe / 100, reciprocal 2^16
    localparam logic [9:0]  R100          = 10'd656;
    localparam int          R100_SHIFT    = 16;
    // (5 * doy + 2) / 153, reciprocal 2^19
    localparam logic [11:0] R153          = 12'd3427;
    localparam int          R153_SHIFT    = 19;

    // Time of day: sod / 3600 = (sod >> 4) / 225; rem / 60 = (rem >> 2) / 15
    localparam logic [13:0] R225          = 14'd9321;
    localparam int          R225_SHIFT    = 21;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [10:0] R15           = 11'd1093;
    localparam int          R15_SHIFT     = 14;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // Era base years and window
    localparam logic [11:0] ERA4_YEAR     = 12'd1600;
    localparam logic [11:0] ERA5_YEAR     = 12'd2000;
    localparam logic [11:0] WIN_FIRST     = 12'd2020;
    localparam logic [11:0] WIN_LAST      = 12'd2099;

    // First day of March-based month mp: (153 * mp + 2) / 5
    function automatic logic [8:0] mp_offset(input logic [3:0] mp);
        logic [8:0] off;
        unique case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

    // Length of a month, 0 for a code that is no month
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            4'd2:                                         len = leap ? 5'd29 : 5'd28;
            default:                                      len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

### rtl/us2utc_civil.sv
// Day count to Gregorian year, month and day, six register stages.
module us2utc_civil (
    input  logic                  i_clk,
    input  us2utc_pkg::t_pipe_ctl i_ctl,
    input  logic [15:0]           i_days,
    output logic [11:0]           o_year,
    output logic [3:0]            o_month,
    output logic [4:0]            o_day
);
    import us2utc_pkg::*;

    logic [19:0] w_shifted;
    logic        w_era5;
    logic [17:0] w_doe;

    logic [17:0] r_doe2, r_doe3, r_doe4;
    logic        r_era2, r_era3, r_era4, r_era5, r_era6;
    logic [17:0] r_t3;
    logic [8:0]  r_yoe4, r_yoe5, r_yoe6;
    logic [8:0]  r_doy5, r_doy6;
    logic [3:0]  r_mp6;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;

    logic [32:0] w_q1460_prod;
    logic [6:0]  w_q1460;
    logic [2:0]  w_q36524;
    logic        w_q146096;
    logic [17:0] w_t;
    logic [36:0] w_yoe_prod;
    logic [18:0] w_q100_prod;
    logic [17:0] w_base;
    logic [10:0] w_v;
    logic [22:0] w_mp_prod;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic [11:0] w_year;

    function automatic logic [15:0] w_doe_q4(input logic [17:0] doe);
        return doe[17:2];
    endfunction

    // Era: the shifted day count always lies in era 4 or era 5
    assign w_shifted = 20'(i_days) + DAYS_TO_EPOCH;
    assign w_era5    = (w_shifted >= ERA5_START);
    assign w_doe     = 18'(w_shifted - (w_era5 ? ERA5_START : ERA4_START));

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[S_SHIFT]) begin
            r_doe2 <= w_doe;
            r_era2 <= w_era5;
        end
    end

    // Leap corrections to the day of era
    assign w_q1460_prod = 33'(w_doe_q4(r_doe2)) * 33'(R365_Q4);
    assign w_q1460      = 7'(w_q1460_prod >> R365_Q4_SHIFT);
    assign w_q36524     = 3'(r_doe2 >= DOE_100Y) + 3'(r_doe2 >= DOE_200Y)
                        + 3'(r_doe2 >= DOE_300Y) + 3'(r_doe2 >= DOE_LAST);
    assign w_q146096    = (r_doe2 == DOE_LAST);
    assign w_t          = r_doe2 - 18'(w_q1460) + 18'(w_q36524) - 18'(w_q146096);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[S_YOE_ARG]) begin
            r_t3   <= w_t;
            r_doe3 <= r_doe2;
            r_era3 <= r_era2;
        end
    end

    // Year of era
    assign w_yoe_prod = 37'(r_t3) * 37'(R365);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[S_YOE]) begin
            r_yoe4 <= 9'(w_yoe_prod >> R365_SHIFT);
            r_doe4 <= r_doe3;
            r_era4 <= r_era3;
        end
    end

    // Day of year, counted from March 1
    assign w_q100_prod = 19'(r_yoe4) * 19'(R100);
    assign w_base      = 18'(r_yoe4) * 18'd365 + 18'(r_yoe4[8:2])
                       - 18'(w_q100_prod >> R100_SHIFT);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[S_DOY]) begin
            r_doy5 <= 9'(r_doe4 - w_base);
            r_yoe5 <= r_yoe4;
            r_era5 <= r_era4;
        end
    end

    // March-based month
    assign w_v       = 11'(r_doy5) * 11'd5 + 11'd2;
    assign w_mp_prod = 23'(w_v) * 23'(R153);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[S_MP]) begin
            r_mp6  <= 4'(w_mp_prod >> R153_SHIFT);
            r_doy6 <= r_doy5;
            r_yoe6 <= r_yoe5;
            r_era6 <= r_era5;
        end
    end

    // Calendar fields, January and February roll into the next year
    assign w_day   = 5'(r_doy6 - mp_offset(r_mp6) + 9'd1);
    assign w_month = (r_mp6 < 4'd10) ? r_mp6 + 4'd3 : r_mp6 - 4'd9;
    assign w_year  = 12'(r_yoe6) + (r_era6 ? ERA5_YEAR : ERA4_YEAR)
                   + 12'(w_month <= 4'd2);

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld[S_DATE]) begin
            r_year  <= w_year;
            r_month <= w_month;
            r_day   <= w_day;
        end
    end

    assign o_year  = r_year;
    assign o_month = r_month;
    assign o_day   = r_day;

endmodule

### rtl/unix_seconds_to_utc_date.sv
// Throughput: one beat per cycle while the output is not stalled; eight register stages, each with a valid bit.
// A stalled output stage holds; bubbles upstream of it still close up.
// Reset (synchronous, active low) clears the valid bits only; no clearing pass.
// Top level: Unix seconds to UTC date and time of day with 2020..2099 window flag.
`include "unix_seconds_to_utc_date_defines.svh"

module unix_seconds_to_utc_date (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [11:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second,
    output logic        o_in_range
);
    import us2utc_pkg::*;

    logic [NUM_STAGES-1:0] r_vld, n_vld, w_ld;
    t_pipe_ctl             w_ctl;

    logic [31:0] r_secs1;
    logic [15:0] r_days1;
    logic [16:0] r_sod2, r_sod3;
    logic [4:0]  r_hh3, r_hh4, r_hh5, r_hh6, r_hh7;
    logic [11:0] r_rem4, r_rem5;
    logic [5:0]  r_mm5, r_mm6, r_mm7;
    logic [5:0]  r_ss6, r_ss7;
    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [4:0]  r_hour;
    logic [5:0]  r_minute;
    logic [5:0]  r_second;
    logic        r_in_range;

    logic [50:0] w_day_prod;
    logic [32:0] w_day_secs;
    logic [26:0] w_hh_prod;
    logic [16:0] w_hh_secs;
    logic [20:0] w_mm_prod;
    logic [11:0] w_mm_secs;
    logic [11:0] w_year;
    logic [3:0]  w_month;
    logic [4:0]  w_day;
    logic        w_leap;
    logic        w_ok;

    // Stage load enables: a stage loads when empty or when its successor loads
    always_comb begin
        w_ld[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
        n_vld[0] = w_ld[0] ? i_valid : r_vld[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_vld[k] = w_ld[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_ctl.ld = w_ld;
    assign o_ready  = w_ld[S_DAYS];
    assign o_valid  = r_vld[S_OUT];

    // Whole days since the epoch
    assign w_day_prod = 51'(i_epoch_seconds[31:7]) * 51'(DAY_RECIP);

    always_ff @(posedge i_clk) begin
        if (w_ld[S_DAYS]) begin
            r_secs1 <= i_epoch_seconds;
            r_days1 <= 16'(w_day_prod >> DAY_SHIFT);
        end
    end

    // Calendar date
    us2utc_civil u_civil (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_days  (r_days1),
        .o_year  (w_year),
        .o_month (w_month),
        .o_day   (w_day)
    );

    // Seconds of the day
    assign w_day_secs = 33'(r_days1) * 33'(SECS_PER_DAY);

    always_ff @(posedge i_clk) begin
        if (w_ld[S_SHIFT]) begin
            r_sod2 <= 17'(r_secs1 - w_day_secs[31:0]);
        end
    end

    // Hour
    assign w_hh_prod = 27'(r_sod2[16:4]) * 27'(R225);

    always_ff @(posedge i_clk) begin
        if (w_ld[S_YOE_ARG]) begin
            r_sod3 <= r_sod2;
            r_hh3  <= 5'(w_hh_prod >> R225_SHIFT);
        end
    end

    // Seconds of the hour
    assign w_hh_secs = 17'(r_hh3) * 17'(SECS_PER_HOUR);

    always_ff @(posedge i_clk) begin
        if (w_ld[S_YOE]) begin
            r_rem4 <= 12'(r_sod3 - w_hh_secs);
            r_hh4  <= r_hh3;
        end
    end

    // Minute
    assign w_mm_prod = 21'(r_rem4[11:2]) * 21'(R15);

    always_ff @(posedge i_clk) begin
        if (w_ld[S_DOY]) begin
            r_mm5  <= 6'(w_mm_prod >> R15_SHIFT);
            r_rem5 <= r_rem4;
            r_hh5  <= r_hh4;
        end
    end

    // Second
    assign w_mm_secs = 12'(r_mm5) * 12'(SECS_PER_MIN);

    always_ff @(posedge i_clk) begin
        if (w_ld[S_MP]) begin
            r_ss6 <= 6'(r_rem5 - w_mm_secs);
            r_mm6 <= r_mm5;
            r_hh6 <= r_hh5;
        end
    end

    // Time fields wait here while the date finishes
    always_ff @(posedge i_clk) begin
        if (w_ld[S_DATE]) begin
            r_ss7 <= r_ss6;
            r_mm7 <= r_mm6;
            r_hh7 <= r_hh6;
        end
    end

    // Window and calendar check; inside the window every fourth year is leap
    assign w_leap = (w_year[1:0] == 2'd0);
    assign w_ok   = (w_year >= WIN_FIRST) && (w_year <= WIN_LAST)
                 && (w_month >= 4'd1) && (w_month <= 4'd12)
                 && (w_day >= 5'd1) && (w_day <= month_len(w_month, w_leap))
                 && (r_hh7 <= 5'd23) && (r_mm7 <= 6'd59) && (r_ss7 <= 6'd59);

    // Output register
    always_ff @(posedge i_clk) begin
        if (w_ld[S_OUT]) begin
            r_year     <= w_year;
            r_month    <= w_month;
            r_day      <= w_day;
            r_hour     <= r_hh7;
            r_minute   <= r_mm7;
            r_second   <= r_ss7;
            r_in_range <= w_ok;
        end
    end

    assign o_year     = r_year;
    assign o_month    = r_month;
    assign o_day      = r_day;
    assign o_hour     = r_hour;
    assign o_minute   = r_minute;
    assign o_second   = r_second;
    assign o_in_range = r_in_range;

    // Checks
    `US2UTC_ASSERT_NXT(a_accept_lands, i_valid && o_ready, r_vld[S_DAYS], "accepted beat lost at entry")
    `US2UTC_ASSERT_IMP(a_stall_only_full, !o_ready, &r_vld, "input stalled with an empty stage")
    `US2UTC_ASSERT_IMP(a_window, o_valid && o_in_range, (o_year >= WIN_FIRST) && (o_year <= WIN_LAST), "in_range outside window")
    `US2UTC_ASSERT_IMP(a_date_span, o_valid, (o_year >= 12'd1970) && (o_year <= 12'd2106) && (o_month >= 4'd1) && (o_month <= 4'd12) && (o_day >= 5'd1), "date field out of span")
    `US2UTC_ASSERT_IMP(a_time_span, o_valid, (o_hour <= 5'd23) && (o_minute <= 6'd59) && (o_second <= 6'd59), "time field out of span")

endmodule
